FILE: rtl/fli_pkg.sv
// Shared widths, codes and types of the frame linear interpolator.
`default_nettype none

package fli_pkg;

	localparam int PIX_W     = 8;             // pixel sample width
	localparam int OFF_W     = 5;             // frame offset width
	localparam int IDX_W     = 16;            // pixel index width
	localparam int INTER_W   = 4;             // inter_count register width
	localparam int DIM_W     = 9;             // width/height register width
	localparam int CFG_IDX_W = 2;             // config register index width
	localparam int CFG_DAT_W = DIM_W;         // widest register
	localparam int CNT_W     = INTER_W;       // shared step counter
	localparam int QUO_W     = PIX_W + 1;     // quotient bits of the step division
	localparam int DIVD_W    = PIX_W + OFF_W; // offset dividend width
	localparam int ALU_W     = OFF_W + 1;     // shared subtractor width

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTER  = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_STEP  = 5'b01000,
		ST_FINAL = 5'b10000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/fli_pix_if.sv
// Input pixel channel: valid/ready handshake with one pixel per transaction.
`default_nettype none

interface fli_pix_if;
	import fli_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_value;
	logic   new_sequence;

	modport source (output valid, output pixel_value, output new_sequence, input ready);
	modport sink   (input valid, input pixel_value, input new_sequence, output ready);
endinterface

`default_nettype wire

FILE: rtl/fli_res_if.sv
// Result channel: valid/ready handshake with one tagged pixel per transaction.
`default_nettype none

interface fli_res_if;
	import fli_pkg::*;

	logic             valid;
	logic             ready;
	pixel_t           interp_value;
	logic [OFF_W-1:0] frame_offset;
	logic [IDX_W-1:0] pixel_index;
	logic             last_of_run;

	modport source (output valid, output interp_value, output frame_offset,
		output pixel_index, output last_of_run, input ready);
	modport sink   (input valid, input interp_value, input frame_offset,
		input pixel_index, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/frame_linear_interpolator_core.sv
// Top level of the frame linear interpolator: sequencer, shared subtractor and frame store.
// A first-frame pixel goes from acceptance straight to its one result. A later pixel is read,
//   divided (9-step restoring division on the shared subtractor) and gives N+1 results, one a
//   cycle while no result waits on ready; the first is registered after ST_READ and ST_DIV.
// A result that waits on ready stalls the steps; the next pixel is taken while the last waits.
// Reset (arst_n low, asynchronous): config to N=1, 256x256, position 0, first frame flagged;
//   the frame store is not cleared and holds garbage until written.
`default_nettype none

module frame_linear_interpolator_core #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned MAX_INTER  = 15
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [fli_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [fli_pkg::CFG_DAT_W-1:0] cfg_wdata,
	fli_pix_if.sink                      pixel,
	fli_res_if.source                    result
);
	import fli_pkg::*;

	localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int          ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int          SIZE_W = $clog2(DEPTH + 1);
	localparam int          W_W    = $clog2(MAX_WIDTH + 1);
	localparam int          H_W    = $clog2(MAX_HEIGHT + 1);
	localparam int          PROD_W = W_W + H_W;

	// configuration registers
	logic [INTER_W-1:0] cfg_inter_q;
	logic [DIM_W-1:0]   cfg_width_q;
	logic [DIM_W-1:0]   cfg_height_q;

	// control
	state_t             state_q;
	logic [ADDR_W-1:0]  pos_q;
	logic               first_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_W-1:0]  size_q;
	logic               out_valid_q;

	// datapath
	pixel_t             pix_q;
	pixel_t             rd_data_q;
	pixel_t             q_q;        // running rounded value
	logic [OFF_W-1:0]   r_q;        // running remainder, below 2d
	logic [INTER_W-1:0] div_rem_q;  // division remainder, below d
	logic [QUO_W-1:0]   shift_q;    // dividend bits out, quotient bits in

	pixel_t             out_value_q;
	logic [OFF_W-1:0]   out_offset_q;
	logic [IDX_W-1:0]   out_index_q;
	logic               out_last_q;

	// frame store
	pixel_t             frame_store [DEPTH];

	// clamped configuration
	logic [31:0]        w_ext, h_ext, n_ext;
	logic [W_W-1:0]     w_clamp;
	logic [H_W-1:0]     h_clamp;
	logic [INTER_W-1:0] n_w;
	logic [OFF_W-1:0]   d_w;
	logic [PROD_W-1:0]  size_full;

	always_comb begin
		w_ext = 32'(cfg_width_q);
		h_ext = 32'(cfg_height_q);
		n_ext = 32'(cfg_inter_q);
		if (w_ext == 32'd0) begin
			w_clamp = W_W'(1);
		end else if (w_ext > MAX_WIDTH) begin
			w_clamp = W_W'(MAX_WIDTH);
		end else begin
			w_clamp = W_W'(w_ext);
		end
		if (h_ext == 32'd0) begin
			h_clamp = H_W'(1);
		end else if (h_ext > MAX_HEIGHT) begin
			h_clamp = H_W'(MAX_HEIGHT);
		end else begin
			h_clamp = H_W'(h_ext);
		end
		if (n_ext > MAX_INTER) begin
			n_w = INTER_W'(MAX_INTER);
		end else begin
			n_w = INTER_W'(n_ext);
		end
	end

	assign d_w       = OFF_W'(n_w) + OFF_W'(1);
	assign size_full = PROD_W'(w_clamp) * PROD_W'(h_clamp);

	// handshakes
	logic in_acc, out_free, emit_step, emit_final;

	assign pixel.ready = (state_q == ST_IDLE);
	assign in_acc      = pixel.valid && pixel.ready;
	assign out_free    = !out_valid_q || result.ready;
	assign emit_step   = (state_q == ST_STEP) && out_free;
	assign emit_final  = (state_q == ST_FINAL) && out_free;

	// frame store port: read at acceptance, write when the new pixel goes out
	logic [ADDR_W-1:0] start_pos, mem_addr;
	logic              mem_re, mem_we, start_first;

	assign start_pos   = pixel.new_sequence ? '0 : pos_q;
	assign start_first = first_q || pixel.new_sequence;
	assign mem_addr    = (state_q == ST_IDLE) ? start_pos : pos_q;
	assign mem_re      = in_acc;
	assign mem_we      = emit_final;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_store[mem_addr] <= pix_q;
		end
		if (mem_re) begin
			rd_data_q <= frame_store[mem_addr];
		end
	end

	// Offset dividend: delta + 256*d is never negative; its quotient is
	// floor(delta/d) + 256, so the low quotient bits give the step modulo 256.
	logic [DIVD_W-1:0] dividend;

	assign dividend = {d_w, {PIX_W{1'b0}}} + DIVD_W'(pix_q) - DIVD_W'(rd_data_q);

	// shared subtract/compare unit
	logic [ALU_W-1:0] sub_a, sub_b;
	logic [ALU_W:0]   diff;
	logic             ge;

	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = {1'b0, div_rem_q, shift_q[QUO_W-1]};
			sub_b = {1'b0, d_w};
		end else begin
			// running remainder plus twice the step remainder, against 2d
			sub_a = {1'b0, r_q} + {1'b0, div_rem_q, 1'b0};
			sub_b = {d_w, 1'b0};
		end
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = !diff[ALU_W];

	pixel_t q_next;

	assign q_next = q_q + shift_q[PIX_W-1:0] + PIX_W'(ge);

	// end-of-frame wrap
	logic [SIZE_W-1:0] pos_inc;
	logic              wrap;

	assign pos_inc = SIZE_W'(pos_q) + SIZE_W'(1);
	assign wrap    = (pos_inc >= size_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_inter_q  <= INTER_W'(1);
			cfg_width_q  <= DIM_W'(256);
			cfg_height_q <= DIM_W'(256);
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			first_q      <= 1'b1;
			cnt_q        <= '0;
			size_q       <= SIZE_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			size_q <= size_full[SIZE_W-1:0];

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INTER:  cfg_inter_q  <= cfg_wdata[INTER_W-1:0];
					CFG_WIDTH:  cfg_width_q  <= cfg_wdata[DIM_W-1:0];
					CFG_HEIGHT: cfg_height_q <= cfg_wdata[DIM_W-1:0];
					default: ;
				endcase
			end

			if (emit_step || emit_final) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q   <= start_pos;
						first_q <= start_first;
						state_q <= start_first ? ST_FINAL : ST_READ;
					end
				end
				ST_READ: begin
					cnt_q   <= CNT_W'(QUO_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(1);
						state_q <= (n_w == '0) ? ST_FINAL : ST_STEP;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_STEP: begin
					if (out_free) begin
						if (cnt_q == n_w) begin
							state_q <= ST_FINAL;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						pos_q   <= wrap ? '0 : pos_inc[ADDR_W-1:0];
						if (wrap) begin
							first_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= pixel.pixel_value;
		end

		if (state_q == ST_READ) begin
			// x = 0: value is prev, remainder of (2*prev*d + d) by 2d is d
			q_q       <= rd_data_q;
			r_q       <= d_w;
			div_rem_q <= dividend[DIVD_W-1 -: INTER_W];
			shift_q   <= dividend[QUO_W-1:0];
		end

		if (state_q == ST_DIV) begin
			div_rem_q <= ge ? diff[INTER_W-1:0] : sub_a[INTER_W-1:0];
			shift_q   <= {shift_q[QUO_W-2:0], ge};
		end

		if (emit_step) begin
			q_q <= q_next;
			r_q <= ge ? diff[OFF_W-1:0] : sub_a[OFF_W-1:0];
		end

		if (emit_step) begin
			out_value_q  <= q_next;
			out_offset_q <= OFF_W'(cnt_q);
			out_index_q  <= IDX_W'(pos_q);
			out_last_q   <= 1'b0;
		end else if (emit_final) begin
			out_value_q  <= pix_q;
			out_offset_q <= first_q ? '0 : d_w;
			out_index_q  <= IDX_W'(pos_q);
			out_last_q   <= 1'b1;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.interp_value = out_value_q;
	assign result.frame_offset = out_offset_q;
	assign result.pixel_index  = out_index_q;
	assign result.last_of_run  = out_last_q;

	// checks
	a_div_rem : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (OFF_W'(div_rem_q) < d_w))
		else $error("division remainder not below divisor");

	a_step_rem : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (ALU_W'(r_q) < {d_w, 1'b0}))
		else $error("running remainder not below twice the divisor");

	a_step_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (cnt_q != '0 && cnt_q <= n_w))
		else $error("intermediate frame offset out of range");

	a_store_last : assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (result.valid && result.last_of_run))
		else $error("store write without closing result");

	a_pos_range : assert property (@(posedge clk) disable iff (!arst_n)
		emit_final |=> (SIZE_W'(pos_q) < size_q))
		else $error("pixel position beyond frame size");

endmodule

`default_nettype wire

FILE: test/tb_frame_linear_interpolator_core.sv
// Self-checking testbench for the frame linear interpolator core.
`timescale 1ns / 100ps

module tb_frame_linear_interpolator_core;
	import fli_pkg::*;

	localparam int unsigned MAX_W        = 256;
	localparam int unsigned MAX_H        = 256;
	localparam int unsigned STORE_DEPTH  = MAX_W * MAX_H;
	localparam int unsigned HOLD_CYCLES  = 400;        // long result hold-off
	localparam int unsigned SETTLE_CYCLES = 40;        // tail after the last result
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;  // many times the slowest clean run
	localparam int unsigned REPORT_LIMIT = 10;

	// One tagged output pixel as the result channel carries it.
	typedef struct packed {
		pixel_t           value;
		logic [OFF_W-1:0] offset;
		logic [IDX_W-1:0] index;
		logic             last;
	} out_pixel_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INTER;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	fli_pix_if pix_ch ();
	fli_res_if res_ch ();

	frame_linear_interpolator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixel     (pix_ch),
		.result    (res_ch)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the frame store, raster position,
	// first-frame flag and the three registers as last written.
	// ------------------------------------------------------------------
	pixel_t             prior_frame   [STORE_DEPTH];
	bit                 prior_written [STORE_DEPTH];
	int unsigned        raster_pos;
	bit                 in_first_frame;
	logic [INTER_W-1:0] inter_reg;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	out_pixel_t         pending_results [$];

	// pacing and back-pressure
	int unsigned send_gap_pct;
	int unsigned take_gap_pct;
	int unsigned hold_left;
	bit          hold_request;   // raised once by the test
	bit          hold_taken;     // set once the hold-off has started

	// bookkeeping
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned pixels_sent;
	int unsigned results_checked;
	int unsigned blends_checked;
	int unsigned restarts;
	int unsigned config_writes;
	int unsigned input_stalls;
	out_pixel_t  seen;
	out_pixel_t  want;

	// Zero means one, anything above the maximum means the maximum.
	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	function automatic int unsigned frame_area();
		return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
	endfunction

	// Bias towards the black and white extremes, otherwise uniform.
	function automatic pixel_t pick_pixel();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return 8'd0;
		if (r < 12)
			return 8'd255;
		return pixel_t'($urandom_range(255));
	endfunction

	// Mostly tiny frames; now and then zero, oversize or exactly the maximum.
	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return DIM_W'($urandom_range(257, 511));
		if (r < 20)
			return DIM_W'(256);
		if (r < 35)
			return DIM_W'($urandom_range(6, 12));
		return DIM_W'($urandom_range(1, 5));
	endfunction

	// Works out every tagged pixel one accepted input causes and updates state.
	// Blend: d = N+1, num = prev*(d-x) + next*x, value = floor((2*num + d) / (2*d)).
	task automatic predict_pixel(input pixel_t pv, input logic ns);
		int unsigned d;
		int unsigned pos;
		int unsigned num;
		out_pixel_t  r;
		if (ns) begin
			raster_pos     = 0;
			in_first_frame = 1'b1;
			restarts++;
		end
		pos     = raster_pos % STORE_DEPTH;
		d       = inter_reg + 1;
		r.index = pos[IDX_W-1:0];
		if (in_first_frame) begin
			r.value  = pv;
			r.offset = '0;
			r.last   = 1'b1;
			pending_results.push_back(r);
		end else begin
			for (int unsigned x = 1; x < d; x++) begin
				num      = prior_frame[pos] * (d - x) + pv * x;
				r.value  = pixel_t'((2 * num + d) / (2 * d));
				r.offset = OFF_W'(x);
				r.last   = 1'b0;
				pending_results.push_back(r);
			end
			r.value  = pv;
			r.offset = OFF_W'(d);
			r.last   = 1'b1;
			pending_results.push_back(r);
		end
		prior_frame[pos]   = pv;
		prior_written[pos] = 1'b1;
		// a position at or beyond the frame (after a shrink) wraps as well
		if (pos + 1 >= frame_area()) begin
			raster_pos     = 0;
			in_first_frame = 1'b0;
		end else begin
			raster_pos = pos + 1;
		end
	endtask

	// One pixel transaction. Valid is left high on return so that a following
	// call can present the next pixel without a bubble.
	task automatic send_pixel(input pixel_t pv, input logic ns);
		logic seq;
		seq = ns;
		// never let a later frame read a store location this sequence has not filled
		if (!seq && !in_first_frame && !prior_written[raster_pos % STORE_DEPTH])
			seq = 1'b1;
		if ($urandom_range(99) < send_gap_pct) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		pix_ch.valid        <= 1'b1;
		pix_ch.pixel_value  <= pv;
		pix_ch.new_sequence <= seq;
		do @(posedge clk); while (!pix_ch.ready);
		predict_pixel(pv, seq);
		pixels_sent++;
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only touched with the core idle.
	task automatic set_config(input logic [INTER_W-1:0] n, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INTER;
		cfg_wdata <= CFG_DAT_W'(n);
		@(posedge clk);
		inter_reg = n;
		cfg_index <= CFG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		width_reg = w;
		cfg_index <= CFG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		height_reg = h;
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// 2x2 frames, N=1: pass-through of the first frame, then blends, two of which land
	// exactly on the half (0 against 255) and round upwards.
	task automatic test_first_frame_and_ties();
		pixel_t opening [4] = '{8'd0, 8'd255, 8'd0, 8'd255};
		pixel_t closing [4] = '{8'd255, 8'd0, 8'd0, 8'd255};
		set_config(4'd1, 9'd2, 9'd2);
		foreach (opening[i])
			send_pixel(opening[i], 1'b0);
		foreach (closing[i])
			send_pixel(closing[i], 1'b0);
	endtask

	// N at both ends; width zero taken as one.
	task automatic test_count_extremes();
		set_config(4'd0, 9'd0, 9'd2);
		send_pixel(8'd17, 1'b0);
		send_pixel(8'd200, 1'b0);
		set_config(4'd15, 9'd2, 9'd1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
	endtask

	// Restart twice, each time at a frame boundary.
	task automatic test_new_sequence();
		send_pixel(8'd33, 1'b1);
		send_pixel(8'd77, 1'b0);
		send_pixel(8'd90, 1'b1);
	endtask

	// Shrink the frame while the position is already past the new size.
	task automatic test_mid_frame_resize();
		set_config(4'd2, 9'd3, 9'd2);
		send_pixel(8'd5, 1'b0);
		send_pixel(8'd250, 1'b0);
		send_pixel(8'd128, 1'b0);
		set_config(4'd2, 9'd1, 9'd2);
		send_pixel(8'd64, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b0);
	endtask

	// Runs of whole frames with random content, cut short by reconfiguration
	// and the odd stray restart. Large frames only get a few pixels.
	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned take_pct,
			input int unsigned budget);
		int unsigned sent;
		int unsigned run_len;
		int unsigned area;
		send_gap_pct = send_pct;
		take_gap_pct = take_pct;
		sent         = 0;
		while (sent < budget) begin
			set_config(INTER_W'($urandom_range(15)), pick_dim(), pick_dim());
			area = frame_area();
			if (area > 64)
				run_len = $urandom_range(2, 10);
			else
				run_len = $urandom_range(1, 3) * area + $urandom_range(0, area - 1);
			if (run_len > budget - sent)
				run_len = budget - sent;
			repeat (run_len)
				send_pixel(pick_pixel(), $urandom_range(99) < 3);
			sent += run_len;
		end
	endtask

	// Height beyond the maximum: one full 256-row column, then part of the next.
	task automatic test_tall_frame();
		set_config(INTER_W'($urandom_range(3)), 9'd1, 9'd511);
		for (int i = 0; i < 264; i++)
			send_pixel(pick_pixel(), i == 0);
	endtask

	// Receiver holds off for a long stretch while pixels keep coming, so the
	// core fills and has to refuse input transactions.
	task automatic test_result_backpressure();
		set_config(4'd15, 9'd4, 9'd1);
		send_gap_pct = 0;
		@(negedge clk) hold_request = 1'b1;
		@(posedge clk);
		repeat (24)
			send_pixel(pick_pixel(), 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Ready with random gaps, or low for a whole hold-off when asked.
	always @(posedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	task automatic note_failure(input string what, input out_pixel_t exp_pix,
			input out_pixel_t got_pix);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t %s: expected value %0d offset %0d index %0d last %0d",
				$realtime, what, exp_pix.value, exp_pix.offset, exp_pix.index, exp_pix.last);
			$display("%0t %s: actual   value %0d offset %0d index %0d last %0d",
				$realtime, what, got_pix.value, got_pix.offset, got_pix.index, got_pix.last);
		end
	endtask

	// Every result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && !pix_ch.ready)
			input_stalls++;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.value  = res_ch.interp_value;
			seen.offset = res_ch.frame_offset;
			seen.index  = res_ch.pixel_index;
			seen.last   = res_ch.last_of_run;
			if (pending_results.size() == 0) begin
				note_failure("result with nothing pending", '0, seen);
			end else begin
				want = pending_results.pop_front();
				if (seen.value !== want.value || seen.offset !== want.offset ||
						seen.index !== want.index || seen.last !== want.last)
					note_failure("result mismatch", want, seen);
				if (!want.last)
					blends_checked++;
			end
			results_checked++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------
	initial begin
		pix_ch.valid        <= 1'b0;
		pix_ch.pixel_value  <= '0;
		pix_ch.new_sequence <= 1'b0;
		raster_pos     = 0;
		in_first_frame = 1'b1;
		inter_reg      = 4'd1;
		width_reg      = 9'd256;
		height_reg     = 9'd256;
		send_gap_pct   = 18;
		take_gap_pct   = 49;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_first_frame_and_ties();
		test_count_extremes();
		test_new_sequence();
		test_mid_frame_resize();

		// sender idles lightly, receiver heavily; then swapped; then flat out
		test_random_traffic(18, 49, 40);
		test_random_traffic(49, 18, 40);
		test_random_traffic(0, 0, 40);
		test_tall_frame();
		test_result_backpressure();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d pixels, %0d results (%0d blended), %0d restarts, %0d settings.",
			pixels_sent, results_checked, blends_checked, restarts, config_writes);
		$display("Input refused for %0d cycles; %0d failures.", input_stalls, fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fli_pkg.sv
rtl/fli_pix_if.sv
rtl/fli_res_if.sv
rtl/frame_linear_interpolator_core.sv
test/tb_frame_linear_interpolator_core.sv
